// File: hdl/color_keyed_sprite_lcd_writer_unit_assert.svh
// assertion macros used by the rtl top
`ifndef COLOR_KEYED_SPRITE_LCD_WRITER_UNIT_ASSERT_SVH
`define COLOR_KEYED_SPRITE_LCD_WRITER_UNIT_ASSERT_SVH

// same-cycle implication
`define CKSLW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CKSLW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ckslw_pkg.sv
`default_nettype none
package ckslw_pkg;

  localparam int unsigned WIN_WRITES = 17;
  localparam int unsigned STEP_W     = $clog2(WIN_WRITES);
  localparam logic [STEP_W-1:0] WIN_LAST = STEP_W'(WIN_WRITES - 1);

  localparam logic [5:0] KEY_RED   = 6'h3f;
  localparam logic [7:0] KEY_GREEN = 8'h00;
  localparam logic [7:0] KEY_BLUE  = 8'h3f;

  localparam logic [7:0] CMD_GRAM  = 8'h22;
  localparam logic [7:0] CMD_HIGH  = 8'h00;

  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_WIDTH    = 2'd2;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  typedef struct packed {
    logic              accept;
    logic              load;
    logic              sel_color;
    logic [STEP_W-1:0] step;
  } ckslw_cmd_t;

  typedef struct packed {
    logic opaque;
    logic window_needed;
    logic out_free;
  } ckslw_status_t;

  // panel address register for a coordinate group, first or second half
  function automatic logic [7:0] win_reg(input logic [1:0] grp, input logic second);
    logic [7:0] base;
    case (grp)
      2'd0: base = 8'h02;
      2'd1: base = 8'h06;
      2'd2: base = 8'h04;
      2'd3: base = 8'h08;
      default: base = 8'h02;
    endcase
    return base | {7'd0, second};
  endfunction

endpackage
`default_nettype wire

// File: hdl/color_keyed_sprite_lcd_writer_unit.sv
// an opaque pixel inside a row passes through the COLOR state into the output register
// a pixel that needs an address window gives 17 window writes first, then its colour write
// throughput: one pixel per cycle within a row while the single output register is free;
// a window holds off the next pixel; transparent pixels give no write
// reset: synchronous, active high; clears counters and held lines, sets window needed
`default_nettype none
`include "color_keyed_sprite_lcd_writer_unit_assert.svh"
module color_keyed_sprite_lcd_writer_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // red_byte, green_byte, blue_byte
  input  wire         s_tlast,   // last_pixel
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // bus_high, bus_low, extra_bit17, extra_bit16, zero pad
  output logic        m_tuser,   // reg_select
  output logic        m_tlast    // last_write
);
  import ckslw_pkg::*;

  ckslw_cmd_t    cmd;
  ckslw_status_t status;

  logic [7:0] bus_high, bus_low;
  logic       extra_bit17, extra_bit16;

  ckslw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ckslw_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .red_byte    (s_tdata[7:0]),
    .green_byte  (s_tdata[15:8]),
    .blue_byte   (s_tdata[23:16]),
    .last_pixel  (s_tlast),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .reg_select  (m_tuser),
    .bus_high    (bus_high),
    .bus_low     (bus_low),
    .extra_bit17 (extra_bit17),
    .extra_bit16 (extra_bit16),
    .last_write  (m_tlast)
  );

  assign m_tdata = {6'd0, extra_bit16, extra_bit17, bus_low, bus_high};

  // a result is never overwritten before it is taken
  `CKSLW_ASSERT_NOW(a_no_overwrite, cmd.load, status.out_free, "load onto pending result")
  // an opaque pixel that needs a window holds off the next pixel
  `CKSLW_ASSERT_NEXT(a_window_stalls, cmd.accept && status.opaque && status.window_needed,
    !s_tready, "input taken during window sequence")
  // the closing write of a pixel is always a colour data write
  `CKSLW_ASSERT_NOW(a_last_is_data, m_tvalid && m_tlast, m_tuser == RS_DATA,
    "last write is not a data write")

endmodule
`default_nettype wire

// File: hdl/ckslw_ctrl.sv
`default_nettype none
module ckslw_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  ckslw_pkg::ckslw_status_t status,
  output ckslw_pkg::ckslw_cmd_t    cmd
);
  import ckslw_pkg::*;

  typedef enum logic [1:0] {IDLE, WINDOW, COLOR} state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_comb begin
    cmd           = '0;
    cmd.step      = step;
    in_ready      = 1'b0;
    state_next    = state;
    step_next     = step;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
      end
      WINDOW: begin
        if (status.out_free) begin
          cmd.load = 1'b1;
          if (step == WIN_LAST) begin
            state_next = COLOR;
          end else begin
            step_next = step + STEP_W'(1);
          end
        end
      end
      COLOR: begin
        if (status.out_free) begin
          cmd.load      = 1'b1;
          cmd.sel_color = 1'b1;
          in_ready      = 1'b1;
          state_next    = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
    cmd.accept = in_valid && in_ready;
    // transparent pixels finish at the transaction itself
    if (cmd.accept && status.opaque) begin
      if (status.window_needed) begin
        state_next = WINDOW;
        step_next  = '0;
      end else begin
        state_next = COLOR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ckslw_datapath.sv
`default_nettype none
module ckslw_datapath (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_we,
  input  wire  [1:0]               cfg_index,
  input  wire  [15:0]              cfg_data,
  input  wire  [7:0]               red_byte,
  input  wire  [7:0]               green_byte,
  input  wire  [7:0]               blue_byte,
  input  wire                      last_pixel,
  input  ckslw_pkg::ckslw_cmd_t    cmd,
  output ckslw_pkg::ckslw_status_t status,
  input  wire                      out_ready,
  output logic                     out_valid,
  output logic                     reg_select,
  output logic [7:0]               bus_high,
  output logic [7:0]               bus_low,
  output logic                     extra_bit17,
  output logic                     extra_bit16,
  output logic                     last_write
);
  import ckslw_pkg::*;

  logic [15:0] origin_x, origin_y;
  logic [7:0]  sprite_width;

  logic [7:0]  column_count, column_next;
  logic [15:0] row_count, row_next;
  logic        window_needed, window_next;
  logic        held_bit17, held_bit16;

  logic [7:0]  pix_red, pix_green, pix_blue;
  logic [15:0] xs, ys, xe;

  logic        opaque;
  logic [7:0]  column_inc;

  logic [1:0]  grp;
  logic [15:0] coord;
  logic        w_rs;
  logic [7:0]  w_high, w_low;

  assign opaque = !(red_byte == {2'b00, KEY_RED} && green_byte == KEY_GREEN &&
                    blue_byte == KEY_BLUE);

  assign status.opaque        = opaque;
  assign status.window_needed = window_needed;
  assign status.out_free      = !out_valid || out_ready;

  assign column_inc = column_count + 8'd1;

  always_comb begin
    column_next = column_inc;
    row_next    = row_count;
    // an opaque pixel uses up the window, a transparent one asks for a fresh one
    window_next = !opaque;
    if (column_inc == sprite_width) begin
      column_next = '0;
      row_next    = row_count + 16'd1;
      window_next = 1'b1;
    end
    if (last_pixel) begin
      column_next = '0;
      row_next    = '0;
      window_next = 1'b1;
    end
  end

  // window sequence: per group cmd first reg, data lo/hi, cmd second reg, data hi/lo
  assign grp = cmd.step[3:2];
  always_comb begin
    case (grp)
      2'd0: coord = xs;
      2'd1: coord = ys;
      2'd2: coord = xe;
      2'd3: coord = ys;
      default: coord = xs;
    endcase
    if (cmd.step == WIN_LAST) begin
      w_rs   = RS_CMD;
      w_high = CMD_HIGH;
      w_low  = CMD_GRAM;
    end else begin
      case (cmd.step[1:0])
        2'd0: begin
          w_rs   = RS_CMD;
          w_high = CMD_HIGH;
          w_low  = win_reg(grp, 1'b0);
        end
        2'd1: begin
          w_rs   = RS_DATA;
          w_high = coord[7:0];
          w_low  = coord[15:8];
        end
        2'd2: begin
          w_rs   = RS_CMD;
          w_high = CMD_HIGH;
          w_low  = win_reg(grp, 1'b1);
        end
        default: begin
          w_rs   = RS_DATA;
          w_high = coord[15:8];
          w_low  = coord[7:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      sprite_width  <= 8'd1;
      column_count  <= '0;
      row_count     <= '0;
      window_needed <= 1'b1;
      held_bit17    <= 1'b0;
      held_bit16    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIGIN_X: origin_x     <= cfg_data;
          CFG_ORIGIN_Y: origin_y     <= cfg_data;
          CFG_WIDTH:    sprite_width <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        column_count  <= column_next;
        row_count     <= row_next;
        window_needed <= window_next;
      end
      if (cmd.load && cmd.sel_color) begin
        held_bit17 <= pix_red[5];
        held_bit16 <= pix_red[4];
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_red   <= red_byte;
      pix_green <= green_byte;
      pix_blue  <= blue_byte;
      xs        <= origin_x + {8'd0, column_count};
      ys        <= origin_y + row_count;
      xe        <= origin_x + {8'd0, sprite_width} - 16'd1;
    end
    if (cmd.load) begin
      if (cmd.sel_color) begin
        reg_select  <= RS_DATA;
        bus_high    <= {pix_red[3:0], pix_green[5:2]};
        bus_low     <= {pix_green[1:0], pix_blue[5:0]};
        extra_bit17 <= pix_red[5];
        extra_bit16 <= pix_red[4];
        last_write  <= 1'b1;
      end else begin
        reg_select  <= w_rs;
        bus_high    <= w_high;
        bus_low     <= w_low;
        extra_bit17 <= held_bit17;
        extra_bit16 <= held_bit16;
        last_write  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_top.sv
module tb_top;
  import ckslw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 24;

  // panel window registers, first and second of each pair
  localparam logic [7:0] REG_HSTART_A = 8'h02;
  localparam logic [7:0] REG_HSTART_B = 8'h03;
  localparam logic [7:0] REG_HEND_A   = 8'h04;
  localparam logic [7:0] REG_HEND_B   = 8'h05;
  localparam logic [7:0] REG_VSTART_A = 8'h06;
  localparam logic [7:0] REG_VSTART_B = 8'h07;
  localparam logic [7:0] REG_VEND_A   = 8'h08;
  localparam logic [7:0] REG_VEND_B   = 8'h09;

  localparam logic [23:0] KEY_PIXEL = {KEY_BLUE, KEY_GREEN, 2'b00, KEY_RED};

  typedef struct {
    logic       reg_select;
    logic [7:0] bus_high;
    logic [7:0] bus_low;
    logic       db17;
    logic       db16;
    logic       last_write;
  } bus_write_t;

  class lcd_bus_model;
    bus_write_t  pending_writes[$];
    int unsigned mismatches;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [7:0]  sprite_width;
    logic [7:0]  column;
    logic [15:0] row;
    logic        window_due;
    logic        held_db17;
    logic        held_db16;

    function new();
      mismatches   = 0;
      origin_x     = '0;
      origin_y     = '0;
      sprite_width = 8'd1;
      column       = '0;
      row          = '0;
      window_due   = 1'b1;
      held_db17    = 1'b0;
      held_db16    = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_ORIGIN_X: origin_x = val;
        CFG_ORIGIN_Y: origin_y = val;
        CFG_WIDTH:    sprite_width = val[7:0];
        default: ;
      endcase
    endfunction

    function void push(logic rs, logic [7:0] hi, logic [7:0] lo);
      bus_write_t w;
      w.reg_select = rs;
      w.bus_high   = hi;
      w.bus_low    = lo;
      w.db17       = held_db17;
      w.db16       = held_db16;
      w.last_write = 1'b0;
      pending_writes.push_back(w);
    endfunction

    // the first data write goes low byte first, the second high byte first
    function void push_coord(logic [7:0] reg_a, logic [7:0] reg_b, logic [15:0] val);
      push(RS_CMD, CMD_HIGH, reg_a);
      push(RS_DATA, val[7:0], val[15:8]);
      push(RS_CMD, CMD_HIGH, reg_b);
      push(RS_DATA, val[15:8], val[7:0]);
    endfunction

    function void take_pixel(logic [23:0] pix, logic is_last);
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [15:0] ys;
      r = pix[7:0];
      g = pix[15:8];
      b = pix[23:16];
      if (pix == KEY_PIXEL) begin
        window_due = 1'b1;
      end else begin
        if (window_due) begin
          ys = origin_y + row;
          push_coord(REG_HSTART_A, REG_HSTART_B, origin_x + {8'h00, column});
          push_coord(REG_VSTART_A, REG_VSTART_B, ys);
          push_coord(REG_HEND_A, REG_HEND_B, origin_x + {8'h00, sprite_width} - 16'd1);
          push_coord(REG_VEND_A, REG_VEND_B, ys);
          push(RS_CMD, CMD_HIGH, CMD_GRAM);
          window_due = 1'b0;
        end
        held_db17 = r[5];
        held_db16 = r[4];
        push(RS_DATA, {r[3:0], g[5:2]}, {g[1:0], b[5:0]});
        pending_writes[pending_writes.size() - 1].last_write = 1'b1;
      end
      column = column + 8'd1;
      if (column == sprite_width) begin
        column     = '0;
        row        = row + 16'd1;
        window_due = 1'b1;
      end
      if (is_last) begin
        column     = '0;
        row        = '0;
        window_due = 1'b1;
      end
    endfunction

    function void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_bus_write(bus_write_t got);
      bus_write_t exp_w;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected bus write, expected none actual rs=%b hi=%h lo=%h",
                 $time, got.reg_select, got.bus_high, got.bus_low);
        mismatches++;
        return;
      end
      exp_w = pending_writes.pop_front();
      check_field("reg_select", {7'd0, exp_w.reg_select}, {7'd0, got.reg_select});
      check_field("bus_high", exp_w.bus_high, got.bus_high);
      check_field("bus_low", exp_w.bus_low, got.bus_low);
      check_field("db17", {7'd0, exp_w.db17}, {7'd0, got.db17});
      check_field("db16", {7'd0, exp_w.db16}, {7'd0, got.db16});
      check_field("last_write", {7'd0, exp_w.last_write}, {7'd0, got.last_write});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [23:0] m_tdata;
  wire         m_tuser;
  wire         m_tlast;

  lcd_bus_model bus_model;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  logic         hold_request = 1'b0;
  logic         hold_taken = 1'b0;
  logic [15:0]  hold_left = '0;
  int unsigned  cycle_count = 0;

  color_keyed_sprite_lcd_writer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receive side: check each transaction, then pick tready for the next cycle
  always @(posedge clk) begin
    bus_write_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.reg_select = m_tuser;
      got.bus_high   = m_tdata[7:0];
      got.bus_low    = m_tdata[15:8];
      got.db17       = m_tdata[16];
      got.db16       = m_tdata[17];
      got.last_write = m_tlast;
      bus_model.check_bus_write(got);
    end
    if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= 16'd300;
      m_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 16'd1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_pixel(logic [23:0] pix, logic is_last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    bus_model.take_pixel(pix, is_last);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (bus_model.pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic set_geometry(logic [15:0] x, logic [15:0] y, logic [7:0] w);
    wait_drained();
    // a trailing transparent pixel gives no write, so let it pass through
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ORIGIN_X;
    cfg_data  <= x;
    @(posedge clk);
    bus_model.set_reg(CFG_ORIGIN_X, x);
    cfg_index <= CFG_ORIGIN_Y;
    cfg_data  <= y;
    @(posedge clk);
    bus_model.set_reg(CFG_ORIGIN_Y, y);
    cfg_index <= CFG_WIDTH;
    cfg_data  <= {8'h00, w};
    @(posedge clk);
    bus_model.set_reg(CFG_WIDTH, {8'h00, w});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] random_pixel();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 15) return KEY_PIXEL;
    if (k < 22) return KEY_PIXEL ^ (24'h1 << $urandom_range(23));
    return 24'($urandom);
  endfunction

  // sprites of random length with random content; with allow_last most end on a final pixel
  task automatic run_sprites(int unsigned count, int unsigned max_len, bit allow_last);
    int unsigned left;
    int unsigned len;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, max_len);
      if (len > left) len = left;
      for (int unsigned i = 0; i < len; i++)
        send_pixel(random_pixel(), allow_last && i == len - 1 && $urandom_range(9) < 8);
      left -= len;
    end
  endtask

  initial begin
    bus_model = new();
    send_idle_pct = 18;
    recv_idle_pct = 49;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset geometry
    send_pixel(24'h563412, 1'b0);
    send_pixel(24'hffffff, 1'b0);

    set_geometry(16'h0000, 16'h0000, 8'd4);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hffffff, 1'b0);
    send_pixel(KEY_PIXEL, 1'b0);
    send_pixel(24'hc0c0c0, 1'b0);
    send_pixel(24'h3f00bf, 1'b0);
    send_pixel(KEY_PIXEL, 1'b0);
    send_pixel(KEY_PIXEL, 1'b0);
    send_pixel(24'h3f403f, 1'b0);
    send_pixel(24'hbf007f, 1'b0);
    send_pixel(KEY_PIXEL, 1'b1);
    send_pixel(24'h3c152a, 1'b1);

    // window end column and later start columns wrap past the top of the range
    set_geometry(16'hfffe, 16'hffff, 8'd255);
    send_pixel(24'h302010, 1'b0);
    send_pixel(24'h804020, 1'b0);
    send_pixel(KEY_PIXEL, 1'b0);
    send_pixel(24'h55aa55, 1'b1);

    set_geometry(16'hffff, 16'hffff, 8'd1);
    send_pixel(24'h030201, 1'b0);
    send_pixel(24'h000030, 1'b0);
    send_pixel(KEY_PIXEL, 1'b0);
    send_pixel(24'hff00ff, 1'b1);

    set_geometry(16'($urandom), 16'($urandom), 8'($urandom_range(2, 12)));
    run_sprites(30, 30, 1'b1);

    // long output stall while items keep coming
    set_geometry(16'hffff, 16'hffff, 8'd1);
    hold_request = 1'b1;
    run_sprites(40, 10, 1'b1);

    send_idle_pct = 49;
    recv_idle_pct = 18;
    set_geometry(16'h0000, 16'h0000, 8'd255);
    run_sprites(20, 20, 1'b1);

    // zero width: the column counter runs through all 256 values
    set_geometry(16'h00f0, 16'h7fff, 8'd0);
    run_sprites(260, 260, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_geometry(16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)));
    run_sprites(20, 20, 1'b1);
    wait_drained();
    run_sprites(20, 20, 1'b1);

    set_geometry(16'($urandom), 16'($urandom), 8'($urandom_range(1, 6)));
    run_sprites(20, 15, 1'b1);

    wait_drained();
    repeat (30) @(posedge clk);
    if (bus_model.mismatches == 0 && bus_model.pending_writes.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/ckslw_pkg.sv
hdl/ckslw_ctrl.sv
hdl/ckslw_datapath.sv
hdl/color_keyed_sprite_lcd_writer_unit.sv
bench/tb_top.sv
